[sv/assert_macros.svh]
// Assertion helpers for the RTL files, used by kts_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define KTS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define KTS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[sv/kts_pkg.sv]
// ----------------------------------------------------------------------------
// kts_pkg
// Types and constants of the knot table spline evaluator.
// ----------------------------------------------------------------------------
package kts_pkg;

   localparam int MAX_KNOTS   = 64;
   localparam int KNOT_AW     = $clog2(MAX_KNOTS);
   localparam int CNT_W       = $clog2(MAX_KNOTS + 1);
   localparam int FRAC_BITS   = 16;
   localparam int DATA_W      = 32;
   localparam int OP_W        = 3;
   localparam int INDEX_W     = 6;
   localparam int STATUS_W    = 2;
   localparam int MSPAN_W     = 17;
   localparam int FRONT_DEPTH = 2;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;
   localparam int DIFF_W      = DATA_W + 1;
   localparam int UNIT_W      = FRAC_BITS + 1;
   localparam int COEF_W      = FRAC_BITS + 4;
   localparam int PROD_W      = DIFF_W + COEF_W;
   localparam int ACC_W       = PROD_W + 3;
   localparam logic [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1) << FRAC_BITS;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND    = 3'd0,
      OP_SET_VALUE = 3'd1,
      OP_SET_TIME  = 3'd2,
      OP_CLEAR     = 3'd3,
      OP_EVAL      = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      K_APPEND, K_SET_VALUE, K_SET_TIME, K_CLEAR, K_EVAL, K_NOP
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK    = 2'd0,
      STS_RANGE = 2'd1,
      STS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      REG_INTERP_MODE = 1'b0,
      REG_MIN_SPAN    = 1'b1
   } reg_idx_type;

   typedef struct packed {
      logic [OP_W-1:0]           operation;
      logic [INDEX_W-1:0]        knot_index;
      logic signed [DATA_W-1:0]  time_in;
      logic signed [DATA_W-1:0]  value_in;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  result_value;
      logic [STATUS_W-1:0]       status;
      logic [CNT_W-1:0]          knot_total;
   } rsp_type;

   typedef struct packed {
      kind_type                  kind;
      logic [KNOT_AW-1:0]        index;
      logic signed [DATA_W-1:0]  time_v;
      logic signed [DATA_W-1:0]  value_v;
   } cmd_type;

   typedef struct packed {
      logic                      interp_mode;
      logic [MSPAN_W-1:0]        min_span;
   } cfg_type;

   typedef struct packed {
      logic                      start;
      logic signed [DIFF_W-1:0]  num;
      logic signed [DIFF_W-1:0]  den;
   } div_req_type;

   typedef struct packed {
      logic                      done;
      logic [UNIT_W-1:0]         quot;
   } div_rsp_type;

endpackage

[sv/kts_front.sv]
// ----------------------------------------------------------------------------
// kts_front
// Accepts request words, decodes the operation and queues commands.
// ----------------------------------------------------------------------------
module kts_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  kts_pkg::req_type  req_word,
   output logic              cmd_valid,
   output kts_pkg::cmd_type  cmd_word,
   input  logic              cmd_take
);
   import kts_pkg::*;

   localparam int PTR_W  = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1;
   localparam int QCNT_W = $clog2(FRONT_DEPTH + 1);

   cmd_type            q_mem [FRONT_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push_ok;
   logic               pop_ok;
   cmd_type            new_cmd;

   function automatic kind_type classify(input logic [OP_W-1:0] op);
      kind_type k;
      unique case (op)
         OP_APPEND:    k = K_APPEND;
         OP_SET_VALUE: k = K_SET_VALUE;
         OP_SET_TIME:  k = K_SET_TIME;
         OP_CLEAR:     k = K_CLEAR;
         OP_EVAL:      k = K_EVAL;
         default:      k = K_NOP;
      endcase
      return k;
   endfunction

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(FRONT_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign req_full  = (count_ff == QCNT_W'(FRONT_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_word  = q_mem[rd_ptr_ff];
   assign push_ok   = req_push & ~req_full;
   assign pop_ok    = cmd_take & cmd_valid;

   always_comb begin
      new_cmd.kind    = classify(req_word.operation);
      new_cmd.index   = KNOT_AW'(req_word.knot_index);
      new_cmd.time_v  = req_word.time_in;
      new_cmd.value_v = req_word.value_in;
      wr_ptr_in = push_ok ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_mem[wr_ptr_ff] <= new_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[sv/kts_div.sv]
// ----------------------------------------------------------------------------
// kts_div
// Serial divider for the unit fraction num * ONE / den, truncated toward
// zero and clamped to [0, ONE]. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module kts_div (
   input  logic                  clock,
   input  logic                  reset,
   input  kts_pkg::div_req_type  div_req,
   output kts_pkg::div_rsp_type  div_rsp
);
   import kts_pkg::*;

   localparam int STEP_W = $clog2(FRAC_BITS + 1);

   typedef enum logic [1:0] {DV_IDLE, DV_LOAD, DV_STEP, DV_DONE} dv_state_type;

   dv_state_type              st_ff, st_in;
   logic signed [DIFF_W-1:0]  num_ff, num_in;
   logic signed [DIFF_W-1:0]  den_ff, den_in;
   logic [DIFF_W-1:0]         dmag_ff, dmag_in;
   logic [DIFF_W:0]           rem_ff, rem_in;
   logic [FRAC_BITS-1:0]      quo_ff, quo_in;
   logic [STEP_W-1:0]         cnt_ff, cnt_in;
   logic                      zero_ff, zero_in;
   logic                      sat_ff, sat_in;
   logic [DIFF_W-1:0]         nmag;
   logic [DIFF_W-1:0]         dmag;
   logic [DIFF_W:0]           shifted;
   logic                      fits;

   assign nmag    = num_ff[DIFF_W-1] ? DIFF_W'(-num_ff) : DIFF_W'(num_ff);
   assign dmag    = den_ff[DIFF_W-1] ? DIFF_W'(-den_ff) : DIFF_W'(den_ff);
   assign shifted = {rem_ff[DIFF_W-1:0], 1'b0};
   assign fits    = (shifted >= {1'b0, dmag_ff});

   always_comb begin
      st_in   = st_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      dmag_in = dmag_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      zero_in = zero_ff;
      sat_in  = sat_ff;
      unique case (st_ff)
         DV_IDLE: begin
            if (div_req.start) begin
               num_in = div_req.num;
               den_in = div_req.den;
               st_in  = DV_LOAD;
            end
         end
         DV_LOAD: begin
            dmag_in = dmag;
            // negative or zero quotients all clamp to zero
            zero_in = (den_ff == '0) || (num_ff == '0) ||
                      (num_ff[DIFF_W-1] != den_ff[DIFF_W-1]);
            sat_in  = (nmag >= dmag);
            rem_in  = {1'b0, nmag};
            quo_in  = '0;
            cnt_in  = STEP_W'(FRAC_BITS);
            st_in   = (zero_in || sat_in) ? DV_DONE : DV_STEP;
         end
         DV_STEP: begin
            rem_in = fits ? (shifted - {1'b0, dmag_ff}) : shifted;
            quo_in = {quo_ff[FRAC_BITS-2:0], fits};
            cnt_in = cnt_ff - STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) begin
               st_in = DV_DONE;
            end
         end
         DV_DONE: begin
            st_in = DV_IDLE;
         end
         default: begin
            st_in = DV_IDLE;
         end
      endcase
   end

   always_comb begin
      div_rsp.done = (st_ff == DV_DONE);
      priority if (zero_ff) begin
         div_rsp.quot = '0;
      end else if (sat_ff) begin
         div_rsp.quot = UNIT_ONE;
      end else begin
         div_rsp.quot = {1'b0, quo_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= DV_IDLE;
      end else begin
         st_ff <= st_in;
      end
      num_ff  <= num_in;
      den_ff  <= den_in;
      dmag_ff <= dmag_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      zero_ff <= zero_in;
      sat_ff  <= sat_in;
   end

endmodule

[sv/kts_back.sv]
// ----------------------------------------------------------------------------
// kts_back
// Executes commands: knot table updates, knot search, fraction divisions and
// the interpolation multiply-accumulate sequence on one shared multiplier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kts_back (
   input  logic                  clock,
   input  logic                  reset,
   input  kts_pkg::cfg_type      cfg,
   input  logic                  cmd_valid,
   input  kts_pkg::cmd_type      cmd_word,
   output logic                  cmd_take,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output kts_pkg::rsp_type      rsp_word,
   output kts_pkg::div_req_type  div_req,
   input  kts_pkg::div_rsp_type  div_rsp
);
   import kts_pkg::*;

   typedef enum logic [3:0] {
      BK_IDLE, BK_CHK_FIRST, BK_CHK_LAST, BK_SCAN, BK_FETCH, BK_CAPT,
      BK_DIV_GO, BK_DIV_WAIT, BK_MUL, BK_ACC, BK_COEF, BK_FINAL
   } bk_state_type;

   typedef enum logic [3:0] {
      MS_L0, MS_L1, MS_M1, MS_M2, MS_U2, MS_U3, MS_H00, MS_H10, MS_H01, MS_H11
   } mul_step_type;

   typedef enum logic [1:0] {DS_U, DS_R1, DS_R2} div_sel_type;

   localparam logic [1:0] SLOT_LAST = 2'd3;

   // knot storage
   logic signed [DATA_W-1:0]  time_mem  [MAX_KNOTS];
   logic signed [DATA_W-1:0]  value_mem [MAX_KNOTS];
   logic signed [DATA_W-1:0]  time_rd_ff;
   logic signed [DATA_W-1:0]  value_rd_ff;
   logic [KNOT_AW-1:0]        rd_addr;
   logic [KNOT_AW-1:0]        wr_addr;
   logic                      wr_time_en;
   logic                      wr_value_en;

   bk_state_type              st_ff, st_in;
   mul_step_type              step_ff, step_in;
   div_sel_type               sel_ff, sel_in;
   logic [CNT_W-1:0]          knot_cnt_ff, knot_cnt_in;
   logic                      res_valid_ff, res_valid_in;
   rsp_type                   res_ff, res_in;
   logic signed [DATA_W-1:0]  tq_ff, tq_in;
   logic [KNOT_AW-1:0]        k_ff, k_in;
   logic [1:0]                slot_ff, slot_in;
   logic                      cap_en;
   logic signed [DATA_W-1:0]  tt_ff [4];
   logic signed [DATA_W-1:0]  pp_ff [4];
   logic signed [DIFF_W-1:0]  d20_ff, d20_in;
   logic signed [DIFF_W-1:0]  d31_ff, d31_in;
   logic [UNIT_W-1:0]         u_ff, u_in;
   logic [UNIT_W-1:0]         r1_ff, r1_in;
   logic [UNIT_W-1:0]         r2_ff, r2_in;
   logic [UNIT_W-1:0]         u2_ff, u2_in;
   logic [UNIT_W-1:0]         u3_ff, u3_in;
   logic signed [DIFF_W-1:0]  m1_ff, m1_in;
   logic signed [DIFF_W-1:0]  m2_ff, m2_in;
   logic signed [COEF_W-1:0]  h00_ff, h00_in;
   logic signed [COEF_W-1:0]  h10_ff, h10_in;
   logic signed [COEF_W-1:0]  h01_ff, h01_in;
   logic signed [COEF_W-1:0]  h11_ff, h11_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;

   logic signed [DIFF_W-1:0]  a_mul;
   logic signed [COEF_W-1:0]  b_mul;
   logic signed [DIFF_W-1:0]  msp;
   logic signed [ACC_W-1:0]   acc_sh;
   logic [ACC_W-DATA_W:0]     acc_top;
   logic signed [DATA_W-1:0]  acc_sat;
   logic signed [COEF_W-1:0]  su, su2, su3, sone;
   logic [CNT_W-1:0]          k_ext;
   logic [CNT_W-1:0]          last_idx;

   function automatic logic signed [DIFF_W-1:0] dsub(
      input logic signed [DATA_W-1:0] a,
      input logic signed [DATA_W-1:0] b
   );
      return DIFF_W'(a) - DIFF_W'(b);
   endfunction

   // tangent divisors are pushed out to +-min_span
   function automatic logic signed [DIFF_W-1:0] hold_span(
      input logic signed [DIFF_W-1:0] d,
      input logic signed [DIFF_W-1:0] m
   );
      logic signed [DIFF_W-1:0] r;
      r = d;
      if (d < 0 && d > -m) begin
         r = -m;
      end else if (d >= 0 && d < m) begin
         r = m;
      end
      return r;
   endfunction

   assign msp      = (cfg.min_span == '0) ? DIFF_W'(1) : DIFF_W'(cfg.min_span);
   assign k_ext    = CNT_W'(k_ff);
   assign last_idx = knot_cnt_ff - CNT_W'(1);

   assign acc_sh  = acc_ff >>> FRAC_BITS;
   assign acc_top = acc_sh[ACC_W-1:DATA_W-1];
   assign acc_sat = ((&acc_top) || !(|acc_top)) ? DATA_W'(acc_sh) :
                    (acc_sh[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                     : {1'b0, {(DATA_W-1){1'b1}}});

   assign su   = COEF_W'(u_ff);
   assign su2  = COEF_W'(u2_ff);
   assign su3  = COEF_W'(u3_ff);
   assign sone = COEF_W'(UNIT_ONE);

   assign rsp_empty = ~res_valid_ff;
   assign rsp_word  = res_ff;

   // multiplier operands
   always_comb begin
      unique case (step_ff)
         MS_L0:   begin a_mul = DIFF_W'(pp_ff[1]); b_mul = COEF_W'(UNIT_ONE - u_ff); end
         MS_L1:   begin a_mul = DIFF_W'(pp_ff[2]); b_mul = COEF_W'(u_ff); end
         MS_M1:   begin a_mul = d20_ff;            b_mul = COEF_W'(UNIT_ONE - r1_ff); end
         MS_M2:   begin a_mul = d31_ff;            b_mul = COEF_W'(UNIT_ONE - r2_ff); end
         MS_U2:   begin a_mul = DIFF_W'(u_ff);     b_mul = COEF_W'(u_ff); end
         MS_U3:   begin a_mul = DIFF_W'(u2_ff);    b_mul = COEF_W'(u_ff); end
         MS_H00:  begin a_mul = DIFF_W'(pp_ff[1]); b_mul = h00_ff; end
         MS_H10:  begin a_mul = m1_ff;             b_mul = h10_ff; end
         MS_H01:  begin a_mul = DIFF_W'(pp_ff[2]); b_mul = h01_ff; end
         MS_H11:  begin a_mul = m2_ff;             b_mul = h11_ff; end
         default: begin a_mul = '0;                b_mul = '0; end
      endcase
   end

   always_comb begin
      st_in        = st_ff;
      step_in      = step_ff;
      sel_in       = sel_ff;
      knot_cnt_in  = knot_cnt_ff;
      res_valid_in = res_valid_ff & ~rsp_pop;
      res_in       = res_ff;
      tq_in        = tq_ff;
      k_in         = k_ff;
      slot_in      = slot_ff;
      cap_en       = 1'b0;
      d20_in       = d20_ff;
      d31_in       = d31_ff;
      u_in         = u_ff;
      r1_in        = r1_ff;
      r2_in        = r2_ff;
      u2_in        = u2_ff;
      u3_in        = u3_ff;
      m1_in        = m1_ff;
      m2_in        = m2_ff;
      h00_in       = h00_ff;
      h10_in       = h10_ff;
      h01_in       = h01_ff;
      h11_in       = h11_ff;
      acc_in       = acc_ff;
      prod_in      = a_mul * b_mul;
      cmd_take     = 1'b0;
      wr_time_en   = 1'b0;
      wr_value_en  = 1'b0;
      wr_addr      = cmd_word.index;
      rd_addr      = '0;
      div_req.start = 1'b0;
      div_req.num   = dsub(tq_ff, tt_ff[1]);
      div_req.den   = dsub(tt_ff[2], tt_ff[1]);

      unique case (st_ff)
         BK_IDLE: begin
            if (cmd_valid && !res_valid_ff) begin
               cmd_take = 1'b1;
               res_in.result_value = '0;
               res_in.status       = STS_OK;
               res_valid_in        = 1'b1;
               unique case (cmd_word.kind)
                  K_APPEND: begin
                     if (knot_cnt_ff >= CNT_W'(MAX_KNOTS)) begin
                        res_in.status = STS_FULL;
                     end else begin
                        wr_addr     = KNOT_AW'(knot_cnt_ff);
                        wr_time_en  = 1'b1;
                        wr_value_en = 1'b1;
                        knot_cnt_in = knot_cnt_ff + CNT_W'(1);
                     end
                  end
                  K_SET_VALUE: begin
                     if (CNT_W'(cmd_word.index) < knot_cnt_ff) begin
                        wr_value_en = 1'b1;
                     end else begin
                        res_in.status = STS_RANGE;
                     end
                  end
                  K_SET_TIME: begin
                     if (CNT_W'(cmd_word.index) < knot_cnt_ff) begin
                        wr_time_en = 1'b1;
                     end else begin
                        res_in.status = STS_RANGE;
                     end
                  end
                  K_CLEAR: begin
                     knot_cnt_in = '0;
                  end
                  K_EVAL: begin
                     if (knot_cnt_ff != '0) begin
                        res_valid_in = 1'b0;
                        tq_in        = cmd_word.time_v;
                        st_in        = BK_CHK_FIRST;
                     end
                  end
                  default: begin
                  end
               endcase
               res_in.knot_total = knot_cnt_in;
            end
         end
         BK_CHK_FIRST: begin
            rd_addr = KNOT_AW'(last_idx);
            if (tq_ff <= time_rd_ff) begin
               res_in.result_value = value_rd_ff;
               res_valid_in        = 1'b1;
               st_in               = BK_IDLE;
            end else begin
               st_in = BK_CHK_LAST;
            end
         end
         BK_CHK_LAST: begin
            rd_addr = KNOT_AW'(1);
            k_in    = KNOT_AW'(1);
            if (tq_ff >= time_rd_ff) begin
               res_in.result_value = value_rd_ff;
               res_valid_in        = 1'b1;
               st_in               = BK_IDLE;
            end else begin
               st_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            // time of knot k is on the read port
            rd_addr = k_ff + KNOT_AW'(1);
            if (k_ext == last_idx || tq_ff < time_rd_ff) begin
               slot_in = '0;
               st_in   = BK_FETCH;
            end else begin
               k_in = k_ff + KNOT_AW'(1);
            end
         end
         BK_FETCH: begin
            // neighbors outside the table repeat the end knots
            unique case (slot_ff)
               2'd0:    rd_addr = (k_ff >= KNOT_AW'(2)) ? k_ff - KNOT_AW'(2)
                                                        : k_ff - KNOT_AW'(1);
               2'd1:    rd_addr = k_ff - KNOT_AW'(1);
               2'd2:    rd_addr = k_ff;
               default: rd_addr = (k_ext + CNT_W'(1) < knot_cnt_ff) ? k_ff + KNOT_AW'(1)
                                                                    : k_ff;
            endcase
            st_in = BK_CAPT;
         end
         BK_CAPT: begin
            cap_en  = 1'b1;
            slot_in = slot_ff + 2'd1;
            if (slot_ff == SLOT_LAST) begin
               sel_in = DS_U;
               st_in  = BK_DIV_GO;
            end else begin
               st_in = BK_FETCH;
            end
         end
         BK_DIV_GO: begin
            div_req.start = 1'b1;
            d20_in = dsub(pp_ff[2], pp_ff[0]);
            d31_in = dsub(pp_ff[3], pp_ff[1]);
            unique case (sel_ff)
               DS_R1: begin
                  div_req.num = dsub(tt_ff[1], tt_ff[0]);
                  div_req.den = hold_span(dsub(tt_ff[2], tt_ff[0]), msp);
               end
               DS_R2: begin
                  div_req.num = dsub(tt_ff[3], tt_ff[2]);
                  div_req.den = hold_span(dsub(tt_ff[3], tt_ff[1]), msp);
               end
               default: begin
               end
            endcase
            st_in = BK_DIV_WAIT;
         end
         BK_DIV_WAIT: begin
            if (div_rsp.done) begin
               unique case (sel_ff)
                  DS_U:    u_in  = div_rsp.quot;
                  DS_R1:   r1_in = div_rsp.quot;
                  default: r2_in = div_rsp.quot;
               endcase
               priority if (sel_ff == DS_U && !cfg.interp_mode) begin
                  step_in = MS_L0;
                  st_in   = BK_MUL;
               end else if (sel_ff == DS_R2) begin
                  step_in = MS_M1;
                  st_in   = BK_MUL;
               end else begin
                  sel_in = (sel_ff == DS_U) ? DS_R1 : DS_R2;
                  st_in  = BK_DIV_GO;
               end
            end
         end
         BK_MUL: begin
            st_in = BK_ACC;
         end
         BK_ACC: begin
            st_in = BK_MUL;
            unique case (step_ff)
               MS_L0: begin
                  acc_in  = ACC_W'(prod_ff);
                  step_in = MS_L1;
               end
               MS_L1: begin
                  acc_in = acc_ff + ACC_W'(prod_ff);
                  st_in  = BK_FINAL;
               end
               MS_M1: begin
                  m1_in   = DIFF_W'(prod_ff >>> FRAC_BITS);
                  step_in = MS_M2;
               end
               MS_M2: begin
                  m2_in   = DIFF_W'(prod_ff >>> FRAC_BITS);
                  step_in = MS_U2;
               end
               MS_U2: begin
                  u2_in   = UNIT_W'(prod_ff >>> FRAC_BITS);
                  step_in = MS_U3;
               end
               MS_U3: begin
                  u3_in = UNIT_W'(prod_ff >>> FRAC_BITS);
                  st_in = BK_COEF;
               end
               MS_H00: begin
                  acc_in  = ACC_W'(prod_ff);
                  step_in = MS_H10;
               end
               MS_H10: begin
                  acc_in  = acc_ff + ACC_W'(prod_ff);
                  step_in = MS_H01;
               end
               MS_H01: begin
                  acc_in  = acc_ff + ACC_W'(prod_ff);
                  step_in = MS_H11;
               end
               default: begin
                  acc_in = acc_ff + ACC_W'(prod_ff);
                  st_in  = BK_FINAL;
               end
            endcase
         end
         BK_COEF: begin
            // Hermite basis weights
            h00_in  = COEF_W'((su3 <<< 1) - (su2 <<< 1) - su2 + sone);
            h10_in  = COEF_W'(su3 - (su2 <<< 1) + su);
            h01_in  = COEF_W'((su2 <<< 1) + su2 - (su3 <<< 1));
            h11_in  = COEF_W'(su3 - su2);
            step_in = MS_H00;
            st_in   = BK_MUL;
         end
         BK_FINAL: begin
            res_in.result_value = acc_sat;
            res_valid_in        = 1'b1;
            st_in               = BK_IDLE;
         end
         default: begin
            st_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_time_en) begin
         time_mem[wr_addr] <= cmd_word.time_v;
      end
      if (wr_value_en) begin
         value_mem[wr_addr] <= cmd_word.value_v;
      end
      time_rd_ff  <= time_mem[rd_addr];
      value_rd_ff <= value_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= BK_IDLE;
         knot_cnt_ff  <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         knot_cnt_ff  <= knot_cnt_in;
         res_valid_ff <= res_valid_in;
      end
      if (cap_en) begin
         tt_ff[slot_ff] <= time_rd_ff;
         pp_ff[slot_ff] <= value_rd_ff;
      end
      step_ff <= step_in;
      sel_ff  <= sel_in;
      res_ff  <= res_in;
      tq_ff   <= tq_in;
      k_ff    <= k_in;
      slot_ff <= slot_in;
      d20_ff  <= d20_in;
      d31_ff  <= d31_in;
      u_ff    <= u_in;
      r1_ff   <= r1_in;
      r2_ff   <= r2_in;
      u2_ff   <= u2_in;
      u3_ff   <= u3_in;
      m1_ff   <= m1_in;
      m2_ff   <= m2_in;
      h00_ff  <= h00_in;
      h10_ff  <= h10_in;
      h01_ff  <= h01_in;
      h11_ff  <= h11_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   `KTS_ASSERT(a_cnt_bound, knot_cnt_ff <= CNT_W'(MAX_KNOTS), "knot count above table size")
   `KTS_ASSERT(a_busy_no_rsp, (st_ff != BK_IDLE) |-> !res_valid_ff, "result pending while busy")
   `KTS_ASSERT(a_scan_range, (st_ff == BK_SCAN) |-> (k_ext < knot_cnt_ff), "scan past last knot")

endmodule

[sv/knot_table_spline_evaluator_core.sv]
// ----------------------------------------------------------------------------
// knot_table_spline_evaluator_core
// Knot table with linear or Catmull-Rom Hermite evaluation, Q16.16.
//
//   channel   direction  handshake            word
//   req_      in         push / full          kts_pkg::req_type
//   rsp_      out        pop / empty          kts_pkg::rsp_type
//   csr_      in         psel/penable/pready  interp_mode @0x0, min_span @0x4
//
// Table updates, clear and no-op words complete in the back end's idle state.
// Evaluate checks the end knots, then runs a linear search to the knot position k
// over the single read port, fetches four knots and runs one serial division for
// linear or three for Hermite; the three serial divisions dominate the Hermite path.
// The knot memories are not cleared by reset.
// A two-word command queue keeps accepting, until full, while a result waits to be popped.
// ----------------------------------------------------------------------------
module knot_table_spline_evaluator_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  kts_pkg::req_type             req_word,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output kts_pkg::rsp_type             rsp_word,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [kts_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [kts_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [kts_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import kts_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   reg_idx_type  reg_sel;
   logic         csr_wr;
   logic         cmd_valid;
   cmd_type      cmd_word;
   logic         cmd_take;
   div_req_type  div_req;
   div_rsp_type  div_rsp;

   assign csr_pready = 1'b1;
   assign reg_sel    = reg_idx_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (reg_sel)
            REG_INTERP_MODE: cfg_in.interp_mode = csr_pwdata[0];
            default:         cfg_in.min_span    = csr_pwdata[MSPAN_W-1:0];
         endcase
      end
      unique case (reg_sel)
         REG_INTERP_MODE: csr_prdata = CSR_DW'(cfg_ff.interp_mode);
         default:         csr_prdata = CSR_DW'(cfg_ff.min_span);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interp_mode <= 1'b0;
         cfg_ff.min_span    <= MSPAN_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   kts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .cmd_valid (cmd_valid),
      .cmd_word  (cmd_word),
      .cmd_take  (cmd_take)
   );

   kts_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   kts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd_word  (cmd_word),
      .cmd_take  (cmd_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

endmodule
